>>> sv/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg: shared types and constants for the insertion sort engine
// Holds the store depth, the value type and the per-cell control struct.
// ----------------------------------------------------------------------------
package iss_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] value_t;

    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

>>> sv/iss_cell.sv
// ----------------------------------------------------------------------------
// iss_cell: one slot of the insertion chain
// Holds one value, flags whether it sorts above the incoming value, and
// takes from its left neighbor or in_value on insert, its right one on drain.
// ----------------------------------------------------------------------------
module iss_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  iss_pkg::cell_ctrl_t ctrl,
    input  iss_pkg::value_t    in_value,
    input  logic               left_gt,
    input  iss_pkg::value_t    left_value,
    input  logic               left_valid,
    input  iss_pkg::value_t    right_value,
    input  logic               right_valid,
    output iss_pkg::value_t    value,
    output logic               valid,
    output logic               gt
);
    import iss_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;

    assign gt = !valid_reg || (value_reg > in_value);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.drain) begin
            value_next = right_value;
            valid_next = right_valid;
        end else if (ctrl.insert) begin
            if (left_gt) begin
                value_next = left_value;
                valid_next = left_valid;
            end else if (gt) begin
                value_next = in_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

>>> sv/insertion_sort_engine.sv
// ----------------------------------------------------------------------------
// insertion_sort_engine: streaming ascending sorter for signed 32-bit runs
//
// Input requests arrive on s_tdata (value) with s_tlast marking the end of a
// run. Each request enters a row of DEPTH compare cells, in which every
// cell compares against the new value and the row shifts right at the
// insertion point, so one request per cycle is taken while loading. Equal
// values stay in arrival order. Requests beyond DEPTH are dropped and the
// overflow flag is set for the run.
// The cycle after the last request, the row drains from its head on m_*:
// ascending, one result per cycle while m_tready is high, m_tlast on the
// final one, m_tuser holding the overflow flag. Every request of a run is
// taken, dropped ones included; s_tready stays low while draining.
// If the receiver stalls, the head result holds on m_tdata and the row waits.
// Reset empties the row and clears the overflow flag; the block starts ready.
// ----------------------------------------------------------------------------
module insertion_sort_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] value
    input  logic                 s_tlast,   // last_item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [31:0] sorted_value
    output logic                 m_tlast,   // last_result
    output logic                 m_tuser    // [0] overflowed
);
    import iss_pkg::*;

    typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

    state_t     state_reg;
    logic       overflow_reg;
    value_t     in_value;
    value_t     cell_value [DEPTH];
    logic       cell_valid [DEPTH];
    logic       cell_gt    [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    cell_ctrl_t ctrl;
    logic       s_fire;
    logic       m_fire;
    logic       full;

    assign in_value = value_t'(s_tdata);
    assign s_tready = (state_reg == ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign full     = cell_valid[DEPTH-1];
    assign m_tvalid = (state_reg == ST_DRAIN) && cell_valid[0];
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = cell_value[0];
    assign m_tlast  = !cell_valid[1];
    assign m_tuser  = overflow_reg;

    assign ctrl.insert = s_fire && !full;
    assign ctrl.drain  = m_fire;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic   l_gt;
            value_t l_value;
            logic   l_valid;
            value_t r_value;
            logic   r_valid;
            if (i == 0) begin : g_head
                assign l_gt    = 1'b0;
                assign l_value = '0;
                assign l_valid = 1'b0;
            end else begin : g_mid
                assign l_gt    = cell_gt[i-1];
                assign l_value = cell_value[i-1];
                assign l_valid = cell_valid[i-1];
            end
            if (i == DEPTH - 1) begin : g_tail
                assign r_value = '0;
                assign r_valid = 1'b0;
            end else begin : g_body
                assign r_value = cell_value[i+1];
                assign r_valid = cell_valid[i+1];
            end
            iss_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .in_value    (in_value),
                .left_gt     (l_gt),
                .left_value  (l_value),
                .left_valid  (l_valid),
                .right_value (r_value),
                .right_valid (r_valid),
                .value       (cell_value[i]),
                .valid       (cell_valid[i]),
                .gt          (cell_gt[i])
            );
            assign valid_vec[i] = cell_valid[i];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            overflow_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (s_fire) begin
                        if (full) begin
                            overflow_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (m_fire && m_tlast) begin
                        state_reg    <= ST_LOAD;
                        overflow_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    a_drain_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> cell_valid[0])
        else $error("drain state with empty head cell");

    a_valid_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec & (valid_vec + {{(DEPTH-1){1'b0}}, 1'b1})) == '0))
        else $error("occupied cells not packed from the head");

    a_overflow_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && full) |=> overflow_reg)
        else $error("dropped request did not raise overflow");

    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> !m_tvalid)
        else $error("result offered while loading");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_tlast) |=> ((valid_vec == '0) && !overflow_reg))
        else $error("row not empty after final result");

endmodule
